>>> design/mvm_pkg.sv
`timescale 1ns / 1ps

package mvm_pkg;

	// Array and sample dimensions.
	localparam int MAX_ROWS    = 64;
	localparam int MAX_COLS    = 64;
	localparam int SAMPLE_BITS = 16;
	localparam int ACC_BITS    = 40;
	localparam int PROD_BITS   = 2 * SAMPLE_BITS;

	localparam int ROW_BITS  = $clog2(MAX_ROWS);
	localparam int COL_BITS  = $clog2(MAX_COLS);
	localparam int ADDR_BITS = ROW_BITS + COL_BITS;
	localparam int CFG_BITS  = 7;

	// Register indexes on the configuration port.
	localparam logic REG_ROWS_IN_USE = 1'b0;
	localparam logic REG_COLS_IN_USE = 1'b1;

	// Input item actions.
	localparam logic ACT_COEF = 1'b0;
	localparam logic ACT_ELEM = 1'b1;

	// Control that travels beside one product through the multiply stage.
	typedef struct packed {
		logic valid;
		logic in_use;
		logic clear;
	} mac_ctl_t;

endpackage

>>> design/mvm_cell.sv
`timescale 1ns / 1ps

// One accumulator of the ring. It takes its neighbor's value on every shift.
module mvm_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              shift_en,
	input  logic [mvm_pkg::ACC_BITS-1:0]      d,
	output logic [mvm_pkg::ACC_BITS-1:0]      q
);

	logic [mvm_pkg::ACC_BITS-1:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (shift_en) begin
			acc_q <= d;
		end
	end

	assign q = acc_q;

endmodule

>>> design/mvm_mac.sv
`timescale 1ns / 1ps

// Registered multiply followed by the accumulate into the ring head.
module mvm_mac (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic signed [mvm_pkg::SAMPLE_BITS-1:0] coef,
	input  logic signed [mvm_pkg::SAMPLE_BITS-1:0] elem,
	input  mvm_pkg::mac_ctl_t                      ctl_s1,
	input  logic [mvm_pkg::ACC_BITS-1:0]           acc_head,
	output mvm_pkg::mac_ctl_t                      ctl_s2,
	output logic [mvm_pkg::ACC_BITS-1:0]           sum
);

	logic signed [mvm_pkg::PROD_BITS-1:0] prod_s2;
	mvm_pkg::mac_ctl_t                    ctl_q_s2;
	logic [mvm_pkg::ACC_BITS-1:0]         base;
	logic [mvm_pkg::ACC_BITS-1:0]         addend;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q_s2 <= '0;
		end else begin
			ctl_q_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= coef * elem;
	end

	// Column zero starts a fresh sum; rows past the rows in use only get cleared.
	always_comb begin
		base   = ctl_q_s2.clear ? '0 : acc_head;
		addend = ctl_q_s2.in_use
			? {{(mvm_pkg::ACC_BITS-mvm_pkg::PROD_BITS){prod_s2[mvm_pkg::PROD_BITS-1]}},
				prod_s2}
			: '0;
		sum    = base + addend;
	end

	assign ctl_s2 = ctl_q_s2;

endmodule

>>> design/matrix_vector_multiply.sv
`timescale 1ns / 1ps

// Channel   Handshake                    Payload
// item      item_valid / item_stall      action, row_index, col_index, value
// result    result_valid / result_stall  row_number, dot_sum, last
// config    cfg_we                       cfg_index, cfg_data
//
// A coefficient write does not stall the item channel. A vector element in a column
// in use stalls the item channel after its transfer, so no new element is taken until
// its pass is through: one multiply-accumulate unit visits all 64 accumulators of the
// ring, one per cycle, through a two-stage coefficient read and multiply pipeline, then
// waits to see it empty. After the last column in use the ring turns once more, handing
// one result per row in use to the output register; stalls on the result side hold it.
// Reset clears the accumulators, sets both counts to 64 and leaves the coefficients unset.
// The item channel is stalled while an element or an emission pass is in progress.

module matrix_vector_multiply (
	input  logic                                   clk,
	input  logic                                   arst_n,

	input  logic                                   item_valid,
	output logic                                   item_stall,
	input  logic                                   action,
	input  logic [mvm_pkg::ROW_BITS-1:0]           row_index,
	input  logic [mvm_pkg::COL_BITS-1:0]           col_index,
	input  logic signed [mvm_pkg::SAMPLE_BITS-1:0] value,

	output logic                                   result_valid,
	input  logic                                   result_stall,
	output logic [mvm_pkg::ROW_BITS-1:0]           row_number,
	output logic signed [mvm_pkg::ACC_BITS-1:0]    dot_sum,
	output logic                                   last,

	input  logic                                   cfg_we,
	input  logic                                   cfg_index,
	input  logic [mvm_pkg::CFG_BITS-1:0]           cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	localparam logic [mvm_pkg::CFG_BITS-1:0] ROWS_MAX = mvm_pkg::CFG_BITS'(mvm_pkg::MAX_ROWS);
	localparam logic [mvm_pkg::CFG_BITS-1:0] COLS_MAX = mvm_pkg::CFG_BITS'(mvm_pkg::MAX_COLS);
	localparam logic [mvm_pkg::ROW_BITS-1:0] ROW_LAST = mvm_pkg::ROW_BITS'(mvm_pkg::MAX_ROWS - 1);

	// Configuration registers, kept as written; the clamp is applied on use.
	logic [mvm_pkg::CFG_BITS-1:0] rows_q;
	logic [mvm_pkg::CFG_BITS-1:0] cols_q;
	logic [mvm_pkg::CFG_BITS-1:0] nrows;
	logic [mvm_pkg::CFG_BITS-1:0] ncols;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROWS_MAX;
			cols_q <= COLS_MAX;
		end else if (cfg_we) begin
			if (cfg_index == mvm_pkg::REG_ROWS_IN_USE) begin
				rows_q <= cfg_data;
			end else begin
				cols_q <= cfg_data;
			end
		end
	end

	// A count of zero acts as one, anything past the maximum acts as the maximum.
	always_comb begin
		nrows = rows_q;
		if (rows_q == '0) begin
			nrows = mvm_pkg::CFG_BITS'(1);
		end else if (rows_q > ROWS_MAX) begin
			nrows = ROWS_MAX;
		end
		ncols = cols_q;
		if (cols_q == '0) begin
			ncols = mvm_pkg::CFG_BITS'(1);
		end else if (cols_q > COLS_MAX) begin
			ncols = COLS_MAX;
		end
	end

	// Item acceptance and decoding.
	logic                                 item_xfer;
	logic [mvm_pkg::CFG_BITS-1:0]         col_ext;
	logic                                 coef_write;
	logic                                 elem_start;

	assign item_xfer  = item_valid && !item_stall;
	assign col_ext    = {1'b0, col_index};
	assign coef_write = item_xfer && (action == mvm_pkg::ACT_COEF);
	// Elements beyond the columns in use are taken and dropped.
	assign elem_start = item_xfer && (action == mvm_pkg::ACT_ELEM) && (col_ext < ncols);

	// Coefficient store, addressed by row then column.
	logic [mvm_pkg::SAMPLE_BITS-1:0] coef_mem [0:(1 << mvm_pkg::ADDR_BITS)-1];
	logic [mvm_pkg::ADDR_BITS-1:0]   rd_addr;
	logic signed [mvm_pkg::SAMPLE_BITS-1:0] coef_s1;

	always_ff @(posedge clk) begin
		if (coef_write) begin
			coef_mem[{row_index, col_index}] <= value;
		end
	end

	always_ff @(posedge clk) begin
		coef_s1 <= coef_mem[rd_addr];
	end

	// Sequencer: issues one row per cycle during an element and one ring step per
	// cycle during emission while no row in use finds the output full.
	state_t                               state_q;
	logic [mvm_pkg::ROW_BITS-1:0]         cnt_q;
	logic [mvm_pkg::COL_BITS-1:0]         col_q;
	logic signed [mvm_pkg::SAMPLE_BITS-1:0] elem_q;
	logic                                 clear_q;
	logic                                 emit_q;
	logic [mvm_pkg::CFG_BITS-1:0]         nrows_q;
	logic                                 out_valid_q;
	logic [mvm_pkg::ROW_BITS-1:0]         row_number_q;
	logic [mvm_pkg::ACC_BITS-1:0]         dot_sum_q;
	logic                                 last_q;

	mvm_pkg::mac_ctl_t                    ctl_s1;
	mvm_pkg::mac_ctl_t                    ctl_s2;
	logic [mvm_pkg::ACC_BITS-1:0]         mac_sum;

	logic [mvm_pkg::ACC_BITS-1:0]         ring_q [0:mvm_pkg::MAX_ROWS-1];
	logic [mvm_pkg::ACC_BITS-1:0]         ring_d [0:mvm_pkg::MAX_ROWS-1];
	logic                                 ring_shift;
	logic [mvm_pkg::ACC_BITS-1:0]         head_in;

	logic                                 out_free;
	logic                                 cnt_in_use;
	logic                                 emit_step;

	assign rd_addr    = {cnt_q, col_q};
	assign out_free   = !out_valid_q || !result_stall;
	assign cnt_in_use = {1'b0, cnt_q} < nrows_q;
	// During emission the ring waits only when a row in use finds the output full.
	assign emit_step  = (state_q == ST_EMIT) && (!cnt_in_use || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// A new row loads the output register; otherwise a taken row empties it.
			if (emit_step && cnt_in_use) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (elem_start) begin
						state_q <= ST_MAC;
					end
				end
				ST_MAC: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == ROW_LAST) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// Wait until the last product has reached the ring.
					if (!ctl_s1.valid && !ctl_s2.valid) begin
						state_q <= emit_q ? ST_EMIT : ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (emit_step) begin
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == ROW_LAST) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Element payload, held for the whole pass.
	always_ff @(posedge clk) begin
		if (elem_start) begin
			col_q   <= col_index;
			elem_q  <= value;
			clear_q <= (col_index == '0);
			emit_q  <= (col_ext == ncols - 1'b1);
			nrows_q <= nrows;
		end
	end

	// Result payload, loaded from the ring head.
	always_ff @(posedge clk) begin
		if (emit_step && cnt_in_use) begin
			row_number_q <= cnt_q;
			dot_sum_q    <= ring_q[0];
			last_q       <= ({1'b0, cnt_q} == nrows_q - 1'b1);
		end
	end

	// Read stage control: one entry per row issued.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid  <= (state_q == ST_MAC);
			ctl_s1.in_use <= cnt_in_use;
			ctl_s1.clear  <= clear_q;
		end
	end

	mvm_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.coef     (coef_s1),
		.elem     (elem_q),
		.ctl_s1   (ctl_s1),
		.acc_head (ring_q[0]),
		.ctl_s2   (ctl_s2),
		.sum      (mac_sum)
	);

	// Accumulator ring. The head cell holds row k when the product for row k
	// arrives; each pass turns the ring exactly once, so row zero is back at the
	// head when the block is idle.
	assign ring_shift = ctl_s2.valid || emit_step;
	assign head_in    = ctl_s2.valid ? mac_sum : ring_q[0];

	for (genvar i = 0; i < mvm_pkg::MAX_ROWS; i++) begin : g_ring
		if (i == mvm_pkg::MAX_ROWS - 1) begin : g_tail
			assign ring_d[i] = head_in;
		end else begin : g_body
			assign ring_d[i] = ring_q[i+1];
		end
		mvm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (ring_shift),
			.d        (ring_d[i]),
			.q        (ring_q[i])
		);
	end

	assign item_stall   = (state_q != ST_IDLE);
	assign result_valid = out_valid_q;
	assign row_number   = row_number_q;
	assign dot_sum      = dot_sum_q;
	assign last         = last_q;

endmodule
